// ===== rtl/lprd_pkg.sv =====
// types and constants shared by the length-prefixed request deframer
package lprd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned AccumW = 32;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CountW-1:0] MaxFrameLenReset = CountW'(4096);
  localparam logic [CountW-1:0] MaxArgCountReset = CountW'(1024);
  localparam logic [CountW-1:0] FieldBytes       = CountW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_FRAME_LEN = 1'b0,
    CFG_MAX_ARG_COUNT = 1'b1
  } lprd_cfg_e;

  typedef enum logic [2:0] {
    PH_FLEN  = 3'd0,
    PH_COUNT = 3'd1,
    PH_SIZE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_HALT  = 3'd4
  } lprd_phase_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_FRAME_LEN = 3'd1,
    ERR_BODY_SHORT = 3'd2,
    ERR_ARG_COUNT = 3'd3,
    ERR_OVERRUN   = 3'd4,
    ERR_TRAILING  = 3'd5
  } lprd_err_e;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              arg_data;
    logic [CountW-1:0] arg_index;
    logic              arg_begin;
    logic [CountW-1:0] arg_length;
    logic              arg_last;
    logic              frame_done;
    logic [ErrW-1:0]   error_code;
  } lprd_res_t;

  typedef struct packed {
    lprd_phase_e phase;
    logic        done;
    lprd_err_e   err;
  } lprd_after_t;

  // decision taken once an argument, or the whole list, is complete
  function automatic lprd_after_t lprd_after_arg(logic [CountW-1:0] args_left,
                                                 logic [CountW-1:0] frame_left);
    lprd_after_t r;
    r.phase = PH_SIZE;
    r.done  = 1'b0;
    r.err   = ERR_NONE;
    if (args_left == '0) begin
      if (frame_left == '0) begin
        r.done  = 1'b1;
        r.phase = PH_FLEN;
      end else begin
        r.err = ERR_TRAILING;
      end
    end else if (frame_left < FieldBytes) begin
      r.err = ERR_OVERRUN;
    end
    return r;
  endfunction

endpackage

// ===== rtl/length_prefixed_request_deframer.sv =====
// length-prefixed request deframer top level
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | in_byte_i
//   out     | output    | out_valid_o / out_stall_i | out_byte_o .. error_code_o
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one byte per cycle while in_stall_o is low: each transaction updates the field and count
// registers and its result lands in the output register on the same edge
// in_stall_o is high only while a result is held and out_stall_i is high
// reset returns to the frame length phase with no error; limits go to 4096 and 1024
// after an error every further transaction returns only the error code
module length_prefixed_request_deframer
  import lprd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    in_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ByteW-1:0]    out_byte_o,
  output logic                arg_data_o,
  output logic [CountW-1:0]   arg_index_o,
  output logic                arg_begin_o,
  output logic [CountW-1:0]   arg_length_o,
  output logic                arg_last_o,
  output logic                frame_done_o,
  output logic [ErrW-1:0]     error_code_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CountW-1:0]   cfg_data_i
);

  lprd_phase_e        phase_q, phase_d;
  logic [1:0]         pos_q, pos_d;
  logic [AccumW-1:0]  acc_q, acc_d;
  logic [CountW-1:0]  frame_left_q, frame_left_d;
  logic [CountW-1:0]  args_left_q, args_left_d;
  logic [CountW-1:0]  cur_arg_q, cur_arg_d;
  logic [CountW-1:0]  arg_left_q, arg_left_d;
  lprd_err_e          err_q, err_d;
  logic [CountW-1:0]  max_frame_len_q, max_arg_count_q;
  lprd_res_t          res_q, res_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic               field_full;
  logic [AccumW-1:0]  acc_new;
  logic [CountW-1:0]  frame_dec;
  logic [CountW-1:0]  args_dec;
  logic [CountW-1:0]  arg_dec;
  lprd_after_t        aft;
  lprd_err_e          raise;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    acc_new = acc_q;
    acc_new[{pos_q, 3'b000} +: ByteW] = in_byte_i;
    if (pos_q == 2'd0) begin
      acc_new = {{(AccumW-ByteW){1'b0}}, in_byte_i};
    end
  end

  assign field_full = (pos_q == 2'd3);
  assign frame_dec  = frame_left_q - CountW'(1);
  assign args_dec   = args_left_q - CountW'(1);
  assign arg_dec    = arg_left_q - CountW'(1);

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    acc_d        = acc_q;
    frame_left_d = frame_left_q;
    args_left_d  = args_left_q;
    cur_arg_d    = cur_arg_q;
    arg_left_d   = arg_left_q;
    err_d        = err_q;
    res_d        = '0;
    raise        = ERR_NONE;
    aft          = '{phase: PH_SIZE, done: 1'b0, err: ERR_NONE};

    case (phase_q)
      PH_FLEN: begin
        pos_d = pos_q + 2'd1;
        acc_d = acc_new;
        if (field_full) begin
          if (acc_new > {{(AccumW-CountW){1'b0}}, max_frame_len_q}) begin
            raise = ERR_FRAME_LEN;
          end else if (acc_new < {{(AccumW-CountW){1'b0}}, FieldBytes}) begin
            raise = ERR_BODY_SHORT;
          end else begin
            frame_left_d = acc_new[CountW-1:0];
            phase_d      = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        frame_left_d = frame_dec;
        pos_d        = pos_q + 2'd1;
        acc_d        = acc_new;
        if (field_full) begin
          if (acc_new > {{(AccumW-CountW){1'b0}}, max_arg_count_q}) begin
            raise = ERR_ARG_COUNT;
          end else begin
            args_left_d      = acc_new[CountW-1:0];
            cur_arg_d        = '0;
            aft              = lprd_after_arg(acc_new[CountW-1:0], frame_dec);
            phase_d          = aft.phase;
            res_d.frame_done = aft.done;
            raise            = aft.err;
          end
        end
      end
      PH_SIZE: begin
        frame_left_d = frame_dec;
        pos_d        = pos_q + 2'd1;
        acc_d        = acc_new;
        if (field_full) begin
          if (acc_new > {{(AccumW-CountW){1'b0}}, frame_dec}) begin
            raise = ERR_OVERRUN;
          end else begin
            res_d.arg_index  = cur_arg_q;
            res_d.arg_begin  = 1'b1;
            res_d.arg_length = acc_new[CountW-1:0];
            if (acc_new == '0) begin
              res_d.arg_last   = 1'b1;
              args_left_d      = args_dec;
              cur_arg_d        = cur_arg_q + CountW'(1);
              aft              = lprd_after_arg(args_dec, frame_dec);
              phase_d          = aft.phase;
              res_d.frame_done = aft.done;
              raise            = aft.err;
            end else begin
              arg_left_d = acc_new[CountW-1:0];
              phase_d    = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        res_d.out_byte  = in_byte_i;
        res_d.arg_data  = 1'b1;
        res_d.arg_index = cur_arg_q;
        frame_left_d    = frame_dec;
        arg_left_d      = arg_dec;
        if (arg_dec == '0) begin
          res_d.arg_last   = 1'b1;
          args_left_d      = args_dec;
          cur_arg_d        = cur_arg_q + CountW'(1);
          aft              = lprd_after_arg(args_dec, frame_dec);
          phase_d          = aft.phase;
          res_d.frame_done = aft.done;
          raise            = aft.err;
        end
      end
      default: begin
        res_d.error_code = err_q;
      end
    endcase

    if (raise != ERR_NONE) begin
      res_d            = '0;
      res_d.error_code = raise;
      err_d            = raise;
      phase_d          = PH_HALT;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FLEN;
      pos_q        <= '0;
      acc_q        <= '0;
      frame_left_q <= '0;
      args_left_q  <= '0;
      cur_arg_q    <= '0;
      arg_left_q   <= '0;
      err_q        <= ERR_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q      <= phase_d;
        pos_q        <= pos_d;
        acc_q        <= acc_d;
        frame_left_q <= frame_left_d;
        args_left_q  <= args_left_d;
        cur_arg_q    <= cur_arg_d;
        arg_left_q   <= arg_left_d;
        err_q        <= err_d;
      end
    end
  end

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_len_q <= MaxFrameLenReset;
      max_arg_count_q <= MaxArgCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_FRAME_LEN: max_frame_len_q <= cfg_data_i;
        CFG_MAX_ARG_COUNT: max_arg_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = res_q.out_byte;
  assign arg_data_o   = res_q.arg_data;
  assign arg_index_o  = res_q.arg_index;
  assign arg_begin_o  = res_q.arg_begin;
  assign arg_length_o = res_q.arg_length;
  assign arg_last_o   = res_q.arg_last;
  assign frame_done_o = res_q.frame_done;
  assign error_code_o = res_q.error_code;

endmodule
